### hw/rtl/csl_pkg.sv
`default_nettype none

package csl_pkg;

  // Field and register widths.
  localparam int unsigned CountW   = 6;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned PosW     = 25;
  localparam int unsigned FracW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned LenW     = 16;
  localparam int unsigned SizeW    = 12;
  localparam int unsigned SpcW     = 13;

  // Requests longer than this are cut to this many items.
  localparam int unsigned MaxItems = 32;

  // Datapath widths, sized for MaxItems items of the largest size and gap.
  localparam int unsigned DvW     = $clog2(MaxItems);
  localparam int unsigned ProdW   = 17;
  localparam int unsigned OvW     = 20;
  localparam int unsigned GapW    = 20;
  localparam int unsigned StW     = 26;
  localparam int unsigned DiffW   = 27;
  localparam int unsigned DivCntW = $clog2(OvW);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgSpanStart  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSpanLength = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgItemOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgItemSize   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMinSpacing = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCentered   = 3'd5;

  // Microprogram addresses.
  localparam int unsigned PcW = 4;
  localparam logic [PcW-1:0] StIdle    = 4'd0;
  localparam logic [PcW-1:0] StProd    = 4'd1;
  localparam logic [PcW-1:0] StOvr     = 4'd2;
  localparam logic [PcW-1:0] StBranch  = 4'd3;
  localparam logic [PcW-1:0] StDivInit = 4'd4;
  localparam logic [PcW-1:0] StDivStep = 4'd5;
  localparam logic [PcW-1:0] StApply   = 4'd6;
  localparam logic [PcW-1:0] StShort   = 4'd7;
  localparam logic [PcW-1:0] StEmit    = 4'd8;
  localparam logic [PcW-1:0] StDone    = 4'd9;

  // Jump conditions: when the condition holds the sequencer goes to the target,
  // otherwise to the next step.
  typedef enum logic [2:0] {
    JcNext      = 3'd0,
    JcAlways    = 3'd1,
    JcNoBeat    = 3'd2,
    JcZeroN     = 3'd3,
    JcNoShrink  = 3'd4,
    JcDivMore   = 3'd5,
    JcEmitWait  = 3'd6
  } jmp_cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic           take_item;
    logic           ld_prod;
    logic           ld_ovr;
    logic           div_init;
    logic           div_step;
    logic           apply_gap;
    logic           apply_short;
    logic           emit;
    jmp_cond_e      cond;
    logic [PcW-1:0] target;
  } uword_t;

  // Control store.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    w = '{default: '0, cond: JcNext};
    unique case (pc)
      StIdle: begin
        w.take_item = 1'b1;
        w.cond      = JcNoBeat;
        w.target    = StIdle;
      end
      StProd: begin
        w.ld_prod = 1'b1;
        w.cond    = JcZeroN;
        w.target  = StIdle;
      end
      StOvr: begin
        w.ld_ovr = 1'b1;
      end
      StBranch: begin
        w.cond   = JcNoShrink;
        w.target = StShort;
      end
      StDivInit: begin
        w.div_init = 1'b1;
      end
      StDivStep: begin
        w.div_step = 1'b1;
        w.cond     = JcDivMore;
        w.target   = StDivStep;
      end
      StApply: begin
        w.apply_gap = 1'b1;
        w.cond      = JcAlways;
        w.target    = StEmit;
      end
      StShort: begin
        w.apply_short = 1'b1;
      end
      StEmit: begin
        w.emit   = 1'b1;
        w.cond   = JcEmitWait;
        w.target = StEmit;
      end
      StDone: begin
        w.cond   = JcAlways;
        w.target = StIdle;
      end
      default: begin
        w.cond   = JcAlways;
        w.target = StIdle;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/csl_item_if.sv
`default_nettype none

// Request channel: one beat carries the item count of one layout.
interface csl_item_if import csl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] item_count;

  modport source (output valid, output item_count, input ready);
  modport sink (input valid, input item_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/csl_result_if.sv
`default_nettype none

// Result channel: one beat per laid-out item.
interface csl_result_if import csl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IdxW-1:0]        item_index;
  logic signed [PosW-1:0] position_fixed;
  logic                   last_item;

  modport source (output valid, output item_index, output position_fixed,
                  output last_item, input ready);
  modport sink (input valid, input item_index, input position_fixed,
                input last_item, output ready);
endinterface

`default_nettype wire

### hw/rtl/centered_spacing_layout.sv
`default_nettype none

// Channel    Dir  Beat contents                               Handshake
// item_i     in   item_count                                  valid / ready
// result_o   out  item_index, position_fixed, last_item       valid / ready
// cfg        in   cfg_idx_i, cfg_data_i                       cfg_we_i, no wait
//
// A request emits one result per item of the saturated count; a request whose gap
// shrinks first runs the 20-step restoring divider. An empty request returns to
// idle from the product step.
// Reset clears the sequencer, the result valid and the configuration registers;
// datapath registers are always loaded before they are read.
// A stalled result holds the emit step; the next request may be taken while the
// last result of the previous run still waits.
module centered_spacing_layout import csl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  csl_item_if.sink                 item_i,
  csl_result_if.source             result_o
);

  localparam logic signed [DiffW-1:0] DiffHi = DiffW'((1 << (PosW - FracW - 1)) - 1);
  localparam logic signed [DiffW-1:0] DiffLo = DiffW'(-(1 << (PosW - FracW - 1)));

  // Configuration registers.
  logic signed [CoordW-1:0] span_start_q;
  logic [LenW-1:0]          span_length_q;
  logic signed [CoordW-1:0] item_offset_q;
  logic [SizeW-1:0]         item_size_q;
  logic signed [SpcW-1:0]   min_spacing_q;
  logic                     centered_q;

  // Sequencer and datapath registers.
  logic [PcW-1:0]         pc_q, pc_d;
  logic [CountW-1:0]      n_q;
  logic [CountW-1:0]      idx_q;
  logic [ProdW-1:0]       prod_q;
  logic signed [OvW-1:0]  ovr_q;
  logic signed [GapW-1:0] gap_q;
  logic signed [StW-1:0]  start_q;
  logic [OvW-1:0]         quo_q;
  logic [DvW-1:0]         rem_q;
  logic [DivCntW-1:0]     div_cnt_q;

  // Result register.
  logic                   out_valid_q, out_valid_d;
  logic [IdxW-1:0]        out_idx_q;
  logic signed [PosW-1:0] out_pos_q;
  logic                   out_last_q;

  uword_t                 uw;
  logic                   jump;
  logic                   emit_fire;
  logic                   is_last;
  logic [CountW-1:0]      n_sat;
  logic [ProdW-1:0]       prod_d;
  logic signed [OvW-1:0]  nm1_s;
  logic signed [OvW-1:0]  spc_prod;
  logic signed [OvW-1:0]  ovr_d;
  logic [DvW-1:0]         divisor;
  logic [DvW+1:0]         trial;
  logic                   trial_ge;
  logic [CountW-1:0]      half_left;
  logic signed [OvW-1:0]  shortfall;
  logic signed [StW-1:0]  advance;
  logic signed [DiffW-1:0] diff;
  logic signed [PosW-1:0] pos_d;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_start_q  <= '0;
      span_length_q <= '0;
      item_offset_q <= '0;
      item_size_q   <= '0;
      min_spacing_q <= '0;
      centered_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSpanStart:  span_start_q  <= cfg_data_i;
        CfgSpanLength: span_length_q <= cfg_data_i;
        CfgItemOffset: item_offset_q <= cfg_data_i;
        CfgItemSize:   item_size_q   <= cfg_data_i[SizeW-1:0];
        CfgMinSpacing: min_spacing_q <= cfg_data_i[SpcW-1:0];
        CfgCentered:   centered_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Current control word and the handshake it drives.
  assign uw           = ucode(pc_q);
  assign item_i.ready = uw.take_item;
  assign emit_fire    = uw.emit && (!out_valid_q || result_o.ready);
  assign is_last      = (idx_q == (n_q - CountW'(1)));

  // Jump condition and next step.
  always_comb begin
    unique case (uw.cond)
      JcNext:     jump = 1'b0;
      JcAlways:   jump = 1'b1;
      JcNoBeat:   jump = !item_i.valid;
      JcZeroN:    jump = (n_q == '0);
      JcNoShrink: jump = !((ovr_q > 0) && (n_q > CountW'(1)));
      JcDivMore:  jump = (div_cnt_q != '0);
      JcEmitWait: jump = !(emit_fire && is_last);
      default:    jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : (pc_q + PcW'(1));
  end

  // Count saturation, run length and overrun.
  assign n_sat    = (item_i.item_count > CountW'(MaxItems)) ? CountW'(MaxItems)
                                                            : item_i.item_count;
  assign prod_d   = ProdW'(n_q) * ProdW'(item_size_q);
  assign nm1_s    = $signed(OvW'(n_q) - OvW'(1));
  assign spc_prod = nm1_s * OvW'(gap_q);
  assign ovr_d    = $signed(OvW'(prod_q)) + spc_prod - $signed(OvW'(span_length_q));

  // One restoring division step: divisor is the number of gaps.
  assign divisor  = DvW'(n_q - CountW'(1));
  assign trial    = {1'b0, rem_q, quo_q[OvW-1]} - {2'b00, divisor};
  assign trial_ge = !trial[DvW+1];

  // Centering after a shrink: the room left equals gaps minus one minus the
  // division remainder, and half of it moves the start.
  assign half_left = (n_q - CountW'(2) - CountW'(rem_q)) >> 1;
  assign shortfall = -ovr_q;

  // Position of the current item with saturation to the result range.
  assign advance = $signed(StW'(item_size_q)) + StW'(gap_q);
  assign diff    = DiffW'(start_q) - DiffW'(item_offset_q);
  always_comb begin
    if (diff > DiffHi) begin
      pos_d = {1'b0, {(PosW-1){1'b1}}};
    end else if (diff < DiffLo) begin
      pos_d = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      pos_d = {diff[PosW-FracW-1:0], FracW'(0)};
    end
  end

  // Result valid follows the emit beats and the sink's ready.
  always_comb begin
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath driven by the control word.
  always_ff @(posedge clk_i) begin
    if (uw.take_item && item_i.valid) begin
      n_q     <= n_sat;
      idx_q   <= '0;
      gap_q   <= GapW'(min_spacing_q);
      start_q <= StW'(span_start_q);
    end
    if (uw.ld_prod) begin
      prod_q <= prod_d;
    end
    if (uw.ld_ovr) begin
      ovr_q <= ovr_d;
    end
    if (uw.div_init) begin
      quo_q     <= OvW'(ovr_q) + OvW'(n_q) - OvW'(2);
      rem_q     <= '0;
      div_cnt_q <= DivCntW'(OvW - 1);
    end
    if (uw.div_step) begin
      rem_q     <= trial_ge ? trial[DvW-1:0] : {rem_q[DvW-2:0], quo_q[OvW-1]};
      quo_q     <= {quo_q[OvW-2:0], trial_ge};
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
    if (uw.apply_gap) begin
      gap_q <= gap_q - $signed(GapW'(quo_q));
      if (centered_q) begin
        start_q <= start_q + $signed(StW'(half_left));
      end
    end
    if (uw.apply_short && (ovr_q < 0) && centered_q) begin
      start_q <= start_q + StW'(shortfall >>> 1);
    end
    if (emit_fire) begin
      out_idx_q  <= idx_q[IdxW-1:0];
      out_pos_q  <= pos_d;
      out_last_q <= is_last;
      start_q    <= start_q + advance;
      idx_q      <= idx_q + CountW'(1);
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.item_index     = out_idx_q;
  assign result_o.position_fixed = out_pos_q;
  assign result_o.last_item      = out_last_q;

endmodule

`default_nettype wire

### bench/centered_spacing_layout_test.sv
`default_nettype none

module centered_spacing_layout_test;
  import csl_pkg::*;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned SettleCycles   = 80;
  localparam int unsigned RandomPhases   = 10;
  localparam int unsigned PhaseRequests  = 29;
  localparam longint      PosHigh        = (longint'(1) <<< (PosW - 1)) - 1;
  localparam longint      PosLow         = -(longint'(1) <<< (PosW - 1));

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // One laid-out item as it should appear on the result channel.
  typedef struct {
    logic [IdxW-1:0]        index;
    logic signed [PosW-1:0] position;
    logic                   last;
  } placement_t;

  // Keeps a copy of the layout registers, computes the positions of each
  // request and matches them against the result beats in order.
  class layout_tracker;
    logic signed [CoordW-1:0] span_start;
    logic [LenW-1:0]          span_length;
    logic signed [CoordW-1:0] item_offset;
    logic [SizeW-1:0]         item_size;
    logic signed [SpcW-1:0]   min_spacing;
    logic                     centered;
    placement_t               expected_q[$];
    int                       errors;

    function new();
      span_start  = '0;
      span_length = '0;
      item_offset = '0;
      item_size   = '0;
      min_spacing = '0;
      centered    = 1'b0;
      errors      = 0;
    endfunction

    function void load_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgSpanStart:  span_start  = data;
        CfgSpanLength: span_length = data;
        CfgItemOffset: item_offset = data;
        CfgItemSize:   item_size   = data[SizeW-1:0];
        CfgMinSpacing: min_spacing = data[SpcW-1:0];
        CfgCentered:   centered    = data[0];
        default: ;
      endcase
    endfunction

    // Works out every position of one request and queues them.
    function void note_request(logic [CountW-1:0] count);
      longint     n;
      longint     gap;
      longint     size;
      longint     len;
      longint     start;
      longint     offset;
      longint     overrun;
      longint     fx;
      int         i;
      placement_t p;
      n      = count;
      gap    = min_spacing;
      size   = item_size;
      len    = span_length;
      start  = span_start;
      offset = item_offset;
      if (n > MaxItems) n = MaxItems;
      if (n == 0) return;
      overrun = n * size + (n - 1) * gap - len;
      // Too long: shrink the gap by the rounded-up share of the overrun.
      if (overrun > 0 && n > 1) begin
        gap = gap - (overrun + n - 2) / (n - 1);
        if (centered) start = start + (len - (n * size + (n - 1) * gap)) / 2;
      end else if (overrun < 0 && centered) begin
        start = start - overrun / 2;
      end
      for (i = 0; i < n; i++) begin
        fx = (start - offset) * 256;
        if (fx < PosLow) fx = PosLow;
        if (fx > PosHigh) fx = PosHigh;
        p.index    = i[IdxW-1:0];
        p.position = fx[PosW-1:0];
        p.last     = (i == n - 1);
        expected_q.push_back(p);
        start = start + size + gap;
      end
    endfunction

    function void check_position(logic [IdxW-1:0] idx, logic signed [PosW-1:0] pos,
                                 logic last);
      placement_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no item outstanding: item_index %0d", idx);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (idx !== want.index) begin
        $error("item_index mismatch: expected %0d, actual %0d", want.index, idx);
        errors++;
      end
      if (pos !== want.position) begin
        $error("position_fixed mismatch: expected %0d, actual %0d", want.position, pos);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_item mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         src_idle_pct;
  int unsigned         snk_stall_pct;
  int unsigned         quiet_cycles;
  layout_tracker       tracker;

  csl_item_if   item_bus ();
  csl_result_if result_bus ();

  centered_spacing_layout dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random; the odds follow the current phase.
  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      tracker.check_position(result_bus.item_index, result_bus.position_fixed,
                             result_bus.last_item);
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("centered_spacing_layout verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    tracker.load_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender back until every result has come and the block has settled.
  task automatic drain();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_layout(logic [CfgDataW-1:0] start, logic [CfgDataW-1:0] length,
                            logic [CfgDataW-1:0] offset, logic [CfgDataW-1:0] size,
                            logic [CfgDataW-1:0] spacing, logic [CfgDataW-1:0] ctr);
    drain();
    write_reg(CfgSpanStart, start);
    write_reg(CfgSpanLength, length);
    write_reg(CfgItemOffset, offset);
    write_reg(CfgItemSize, size);
    write_reg(CfgMinSpacing, spacing);
    write_reg(CfgCentered, ctr);
    write_reg(($urandom_range(1) != 0) ? CfgSpareHi : CfgSpareLo, CfgDataW'($urandom));
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IdleNone:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IdleSender:   begin src_idle_pct = 60; snk_stall_pct = 0;  end
      IdleReceiver: begin src_idle_pct = 0;  snk_stall_pct = 60; end
      default:      begin src_idle_pct = 32; snk_stall_pct = 32; end
    endcase
  endtask

  // Sends one request beat after an optional random gap.
  task automatic send(logic [CountW-1:0] count);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.item_count <= count;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    tracker.note_request(count);
  endtask

  // Favors the range ends now and then.
  function automatic int pick(int lo, int hi);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Mostly short runs, some full ones, some empty and some over the limit.
  function automatic logic [CountW-1:0] random_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return CountW'($urandom_range(63, MaxItems + 1));
    if (r < 60) return CountW'($urandom_range(6, 1));
    return CountW'($urandom_range(MaxItems, 1));
  endfunction

  initial begin
    tracker = new();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    item_bus.valid      <= 1'b0;
    item_bus.item_count <= '0;
    quiet_cycles        <= 0;
    set_idle(IdleNone);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Plain left-aligned run: empty, single, short, full and oversized requests.
    set_layout(16'd100, 16'd1000, 16'd10, 16'd50, 16'd10, 16'd0);
    send(6'd0);
    send(6'd1);
    send(6'd3);
    send(6'd32);
    send(6'd63);

    // Centered: a short run, a run that must shrink, and a saturated count.
    set_layout(16'd100, 16'd1000, 16'd10, 16'd50, 16'd10, 16'd1);
    send(6'd5);
    send(6'd20);
    send(6'd40);

    // Exact fit keeps the start in place.
    set_layout(16'd100, 16'd230, 16'd10, 16'd50, 16'd10, 16'd1);
    send(6'd4);

    // A single item that does not fit is left alone; two of them shrink.
    set_layout(16'd100, 16'd30, 16'd10, 16'd50, 16'd10, 16'd1);
    send(6'd1);
    send(6'd2);

    // Positions climb past the top of the fixed-point range.
    set_layout(16'(32767), 16'd65535, 16'(-32768), 16'd4095, 16'(4095), 16'd0);
    send(6'd8);
    send(6'd33);

    // Positions fall past the bottom; odd negative shortfall when centered.
    set_layout(16'(-32768), 16'd65535, 16'(32767), 16'd0, 16'(-4096), 16'd1);
    send(6'd32);
    send(6'd2);

    // Everything zero.
    set_layout(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send(6'd1);
    send(6'd17);

    // Odd leftovers on both sides of an exact fit.
    set_layout(16'd0, 16'd101, 16'd0, 16'd10, 16'd5, 16'd1);
    send(6'd10);
    send(6'd7);

    // Random layouts, one register setting per phase, idling cycling through modes.
    for (int p = 0; p < RandomPhases; p++) begin
      set_idle(idle_mode_e'(p % 4));
      set_layout(16'(pick(-32768, 32767)), 16'(pick(0, 65535)),
                 16'(pick(-32768, 32767)), {4'($urandom), 12'(pick(0, 4095))},
                 {3'($urandom), 13'(pick(-4096, 4095))},
                 {15'($urandom), 1'($urandom)});
      for (int k = 0; k < PhaseRequests; k++) send(random_count());
    end

    drain();
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("centered_spacing_layout verification clean");
    end else begin
      $display("centered_spacing_layout verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
